FILE: design/idpool_pkg.sv
package idpool_pkg;

   localparam int unsigned ID_W         = 9;
   localparam int unsigned HANDLE_W     = 32;
   localparam int unsigned ACTION_W     = 2;
   localparam int unsigned STATUS_W     = 2;

   localparam int unsigned MAX_IDS_DEF     = 256;
   localparam int unsigned HANDLE_BITS_DEF = 32;

   localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADREL = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0]     req_id;
      logic [HANDLE_W-1:0] req_handle;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     got_id;
      logic [HANDLE_W-1:0] got_handle;
      logic                found;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

FILE: design/idpool_slot_table.sv
module idpool_slot_table #(
   parameter int unsigned DEPTH = idpool_pkg::MAX_IDS_DEF,
   parameter int unsigned HB    = idpool_pkg::HANDLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     wr_mark,
   input  logic [HB-1:0]            wr_handle,
   output logic                     rd_mark,
   output logic [HB-1:0]            rd_handle
);

   logic [HB:0] mem_ff [DEPTH];
   logic [HB:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_mark, wr_handle};
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_mark   = rd_word_ff[HB];
   assign rd_handle = rd_word_ff[HB-1:0];

endmodule

FILE: design/idpool_free_stack.sv
module idpool_free_stack #(
   parameter int unsigned DEPTH = idpool_pkg::MAX_IDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  idpool_pkg::stack_ctl_type      ctl,
   input  logic [$clog2(DEPTH)-1:0]       push_data,
   output logic [$clog2(DEPTH)-1:0]       top_data,
   output idpool_pkg::stack_stat_type     stat
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [AW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] top_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_dec;

   assign count_dec = count_ff - CW'(1);

   always_comb begin
      count_in = count_ff;
      if (ctl.pop) begin
         count_in = count_dec;
      end else if (ctl.push) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[count_ff[AW-1:0]] <= push_data;
      end
      if (ctl.pop) begin
         top_ff <= mem_ff[count_dec[AW-1:0]];
      end
   end

   assign top_data = top_ff;
   assign stat     = '{empty: (count_ff == '0), full: (32'(count_ff) == 32'(DEPTH))};

endmodule

FILE: design/id_pool_allocator.sv
// ID pool allocator. Pulse start with a request while busy is low; busy then stays high
// for one cycle and the answer appears on rsp for exactly one cycle, flagged by rsp_valid,
// starting in the cycle after busy; a new request is taken only while busy is low, since
// the slot table and free stack are synchronous memories, read when a request is accepted
// and updated while busy. Allocate hands out the most recently released ID, or else the
// next fresh ID, and binds req_handle to it; release frees a live ID; lookup returns the
// bound handle with found set. Results cannot be held off, so capture each one when it
// is flagged. A full pool answers status 1 with ID 0, and a bad release answers status 2.
module id_pool_allocator #(
   parameter int unsigned MAX_IDS     = idpool_pkg::MAX_IDS_DEF,
   parameter int unsigned HANDLE_BITS = idpool_pkg::HANDLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  idpool_pkg::req_type req,
   output logic                rsp_valid,
   output idpool_pkg::rsp_type rsp
);

   localparam int unsigned AW = $clog2(MAX_IDS);
   localparam int unsigned CW = $clog2(MAX_IDS + 1);

   logic                          accept;
   logic                          busy_ff;
   logic [CW-1:0]                 hw_ff;
   logic [CW-1:0]                 hw_in;
   logic                          rsp_valid_ff;
   idpool_pkg::rsp_type           rsp_ff;
   idpool_pkg::rsp_type           rsp_in;

   logic [idpool_pkg::ACTION_W-1:0] act_ff;
   logic [AW-1:0]                 idx_ff;
   logic                          inrng_ff;
   logic                          pop_ff;
   logic [HANDLE_BITS-1:0]        handle_ff;

   logic [31:0]                   id_m1;
   logic                          in_range;
   logic [63:0]                   req_h64;
   logic [63:0]                   rd_h64;
   logic [31:0]                   nid_wide;
   logic                          pop_req;

   idpool_pkg::stack_ctl_type     stk_ctl;
   idpool_pkg::stack_stat_type    stk_stat;
   logic [AW-1:0]                 stk_top;

   logic                          slot_wr_en;
   logic [AW-1:0]                 slot_wr_addr;
   logic                          slot_wr_mark;
   logic                          slot_rd_mark;
   logic [HANDLE_BITS-1:0]        slot_rd_handle;

   assign accept   = start && !busy_ff;
   assign id_m1    = 32'(req.req_id) - 32'd1;
   assign in_range = (req.req_id != '0) && (32'(req.req_id) <= 32'(hw_ff));
   assign req_h64  = 64'(req.req_handle);
   assign rd_h64   = 64'(slot_rd_handle);
   assign nid_wide = 32'(slot_wr_addr) + 32'd1;

   assign pop_req = accept && (req.action == idpool_pkg::ACT_ALLOC) && !stk_stat.empty;

   idpool_slot_table #(
      .DEPTH (MAX_IDS),
      .HB    (HANDLE_BITS)
   ) u_slots (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (id_m1[AW-1:0]),
      .wr_en     (slot_wr_en),
      .wr_addr   (slot_wr_addr),
      .wr_mark   (slot_wr_mark),
      .wr_handle (handle_ff),
      .rd_mark   (slot_rd_mark),
      .rd_handle (slot_rd_handle)
   );

   idpool_free_stack #(
      .DEPTH (MAX_IDS)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stk_ctl),
      .push_data (idx_ff),
      .top_data  (stk_top),
      .stat      (stk_stat)
   );

   // work stage while busy: modify and write back; the stack pop is issued on accept
   always_comb begin
      rsp_in        = '0;
      hw_in         = hw_ff;
      slot_wr_en    = 1'b0;
      slot_wr_addr  = idx_ff;
      slot_wr_mark  = 1'b0;
      stk_ctl.pop   = pop_req;
      stk_ctl.push  = 1'b0;
      if (busy_ff) begin
         unique case (act_ff)
            idpool_pkg::ACT_ALLOC: begin
               if (pop_ff) begin
                  slot_wr_en    = 1'b1;
                  slot_wr_addr  = stk_top;
                  slot_wr_mark  = 1'b1;
                  rsp_in.got_id = nid_wide[idpool_pkg::ID_W-1:0];
               end else if (32'(hw_ff) < 32'(MAX_IDS)) begin
                  slot_wr_en    = 1'b1;
                  slot_wr_addr  = hw_ff[AW-1:0];
                  slot_wr_mark  = 1'b1;
                  hw_in         = hw_ff + CW'(1);
                  rsp_in.got_id = nid_wide[idpool_pkg::ID_W-1:0];
               end else begin
                  rsp_in.status = idpool_pkg::ST_FULL;
               end
            end
            idpool_pkg::ACT_RELEASE: begin
               if (inrng_ff && slot_rd_mark && !stk_stat.full) begin
                  slot_wr_en   = 1'b1;
                  stk_ctl.push = 1'b1;
               end else begin
                  rsp_in.status = idpool_pkg::ST_BADREL;
               end
            end
            idpool_pkg::ACT_LOOKUP: begin
               if (inrng_ff && slot_rd_mark) begin
                  rsp_in.found      = 1'b1;
                  rsp_in.got_handle = rd_h64[idpool_pkg::HANDLE_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hw_ff        <= '0;
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
         hw_ff        <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= req.action;
         idx_ff    <= id_m1[AW-1:0];
         inrng_ff  <= in_range;
         pop_ff    <= pop_req;
         handle_ff <= req_h64[HANDLE_BITS-1:0];
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_one_cycle_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("work stage held longer than one cycle");

   a_beat_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy_ff))
      else $error("result beat without a request in work");

   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.found |-> rsp.status == idpool_pkg::ST_OK && rsp.got_id == '0)
      else $error("lookup hit with stray fields");

   a_full_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != idpool_pkg::ST_OK |-> rsp.got_id == '0 && !rsp.found)
      else $error("error status with an id granted");
`endif

endmodule
